/* rtl/pidc_pkg.sv */
`default_nettype none

package pidc_pkg;

    // Fixed shape of the controller
    localparam int AXIS_COUNT      = 3;
    localparam int VALUE_WIDTH_DEF = 16;
    localparam int FRAC_BITS       = 7;
    localparam int DT_ONE          = 1 << FRAC_BITS;

    // Axis order, which is also the register order of the gain words
    localparam int AXIS_ROLL  = 0;
    localparam int AXIS_PITCH = 1;
    localparam int AXIS_YAW   = 2;

    // Register map indexes
    localparam int REG_TIME_STEP = AXIS_COUNT;
    localparam int REG_COUNT     = AXIS_COUNT + 1;

    // Lane sequencer states
    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_MUL_P  = 11'b000_0000_0010,
        ST_MUL_I1 = 11'b000_0000_0100,
        ST_MUL_I2 = 11'b000_0000_1000,
        ST_MUL_I3 = 11'b000_0001_0000,
        ST_DIV    = 11'b000_0010_0000,
        ST_FIX    = 11'b000_0100_0000,
        ST_MUL_D1 = 11'b000_1000_0000,
        ST_MUL_D2 = 11'b001_0000_0000,
        ST_SUM    = 11'b010_0000_0000,
        ST_DONE   = 11'b100_0000_0000
    } lane_state_t;

    // Control from the top level to a lane
    typedef struct packed {
        logic start;
        logic take;
    } lane_ctrl_t;

    // Status from a lane to the top level and the merge stage
    typedef struct packed {
        logic idle;
        logic done;
    } lane_stat_t;

endpackage

`default_nettype wire

/* rtl/three_axis_pid_controller.sv */
`default_nettype none

// Three-axis PID controller, signed fixed point with 7 fraction bits.
// Input channel (in_valid/in_ready) carries target and measured angle for
// roll, pitch and yaw; output channel (out_valid/out_ready) returns one item
// with the three drive values. Gains (Kp, Ki, Kd packed per axis) and the
// time step are written over the APB port; the user must write them only
// while the block is idle, as the block itself does not enforce this.
// One lane per axis runs its own sequencer around one multiplier and a
// one-bit-per-cycle divider for the derivative quotient, which takes
// VALUE_WIDTH + 7 divide steps; a zero time step skips the divide.
// One item is in work at a time; in_ready returns high in the cycle the
// result enters the output register, so a new item is taken only once the
// last one has left the lanes.
// A stalled receiver holds the output register; the lanes then keep their
// finished results and in_ready stays low until the register frees.
// Reset clears gains to zero, time step to 1.0, integrals and previous
// errors to zero, and empties the output register.

module three_axis_pid_controller #(
    parameter int VALUE_WIDTH = pidc_pkg::VALUE_WIDTH_DEF,
    localparam int DATA_W = ((3 * VALUE_WIDTH + 31) / 32) * 32,
    localparam int STRIDE = DATA_W / 8,
    localparam int ADDR_W = $clog2(STRIDE * pidc_pkg::REG_COUNT)
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ADDR_W-1:0]      paddr,
    input  wire logic [DATA_W-1:0]      pwdata,
    output logic      [DATA_W-1:0]      prdata,
    output logic                        pready,
    // Input channel
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [VALUE_WIDTH-1:0] roll_target,
    input  wire logic [VALUE_WIDTH-1:0] roll_measured,
    input  wire logic [VALUE_WIDTH-1:0] pitch_target,
    input  wire logic [VALUE_WIDTH-1:0] pitch_measured,
    input  wire logic [VALUE_WIDTH-1:0] yaw_target,
    input  wire logic [VALUE_WIDTH-1:0] yaw_measured,
    // Output channel
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [VALUE_WIDTH-1:0]      roll_drive,
    output logic [VALUE_WIDTH-1:0]      pitch_drive,
    output logic [VALUE_WIDTH-1:0]      yaw_drive
);

    localparam int W      = VALUE_WIDTH;
    localparam int GW     = 3 * VALUE_WIDTH;
    localparam int SHIFT  = $clog2(STRIDE);
    localparam int IDX_W  = ADDR_W - SHIFT;
    localparam int AXES   = pidc_pkg::AXIS_COUNT;

    logic [GW-1:0]    gains_reg [AXES];
    logic [W-1:0]     dt_reg;
    logic [IDX_W-1:0] reg_idx;
    logic             wr_en;

    pidc_pkg::lane_ctrl_t lane_ctrl;
    pidc_pkg::lane_stat_t lane_stat  [AXES];
    logic [W-1:0]         lane_drive [AXES];
    logic [W-1:0]         lane_tgt   [AXES];
    logic [W-1:0]         lane_meas  [AXES];
    logic [W-1:0]         out_drive  [AXES];
    logic                 take;
    logic                 all_idle;

    // Register decode
    assign reg_idx = paddr[ADDR_W-1:SHIFT];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // Gain registers, one per axis
    for (genvar a = 0; a < AXES; a++)
    begin : g_gain
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                gains_reg[a] <= '0;
            else if (wr_en && (reg_idx == IDX_W'(a)))
                gains_reg[a] <= pwdata[GW-1:0];
        end
    end

    // Time step register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dt_reg <= W'(pidc_pkg::DT_ONE);
        else if (wr_en && (reg_idx == IDX_W'(pidc_pkg::REG_TIME_STEP)))
            dt_reg <= pwdata[W-1:0];
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        for (int a = 0; a < AXES; a++)
        begin
            if (reg_idx == IDX_W'(a))
                prdata = DATA_W'(gains_reg[a]);
        end
        if (reg_idx == IDX_W'(pidc_pkg::REG_TIME_STEP))
            prdata = DATA_W'(dt_reg);
    end

    // Accept a new item only when every lane is free
    always_comb
    begin
        all_idle = 1'b1;
        for (int a = 0; a < AXES; a++)
            all_idle = all_idle & lane_stat[a].idle;
    end

    assign in_ready        = all_idle;
    assign lane_ctrl.start = in_valid && in_ready;
    assign lane_ctrl.take  = take;

    // Map axis fields onto lanes
    assign lane_tgt[pidc_pkg::AXIS_ROLL]   = roll_target;
    assign lane_meas[pidc_pkg::AXIS_ROLL]  = roll_measured;
    assign lane_tgt[pidc_pkg::AXIS_PITCH]  = pitch_target;
    assign lane_meas[pidc_pkg::AXIS_PITCH] = pitch_measured;
    assign lane_tgt[pidc_pkg::AXIS_YAW]    = yaw_target;
    assign lane_meas[pidc_pkg::AXIS_YAW]   = yaw_measured;

    for (genvar a = 0; a < AXES; a++)
    begin : g_lane
        pidc_lane #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (lane_ctrl),
            .stat      (lane_stat[a]),
            .target    (lane_tgt[a]),
            .measured  (lane_meas[a]),
            .kp        (gains_reg[a][W-1:0]),
            .ki        (gains_reg[a][2*W-1:W]),
            .kd        (gains_reg[a][3*W-1:2*W]),
            .time_step (dt_reg),
            .drive     (lane_drive[a])
        );
    end

    pidc_merge #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane_stat  (lane_stat),
        .lane_drive (lane_drive),
        .take       (take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .drive      (out_drive)
    );

    assign roll_drive  = out_drive[pidc_pkg::AXIS_ROLL];
    assign pitch_drive = out_drive[pidc_pkg::AXIS_PITCH];
    assign yaw_drive   = out_drive[pidc_pkg::AXIS_YAW];

endmodule

`default_nettype wire

/* rtl/pidc_lane.sv */
`default_nettype none

module pidc_lane #(
    parameter int VALUE_WIDTH = pidc_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire pidc_pkg::lane_ctrl_t    ctrl,
    output pidc_pkg::lane_stat_t         stat,
    input  wire logic [VALUE_WIDTH-1:0]  target,
    input  wire logic [VALUE_WIDTH-1:0]  measured,
    input  wire logic [VALUE_WIDTH-1:0]  kp,
    input  wire logic [VALUE_WIDTH-1:0]  ki,
    input  wire logic [VALUE_WIDTH-1:0]  kd,
    input  wire logic [VALUE_WIDTH-1:0]  time_step,
    output logic      [VALUE_WIDTH-1:0]  drive
);

    localparam int W  = VALUE_WIDTH;
    localparam int F  = pidc_pkg::FRAC_BITS;
    localparam int IB = W + 2 * F;       // bits kept of Ki*e*dt
    localparam int NB = W + F;           // quotient bits, also Kd*q bits kept
    localparam int CW = $clog2(NB);

    pidc_pkg::lane_state_t state_reg;

    logic [W-1:0]    e_reg;
    logic [W-1:0]    last_e_reg;
    logic [W-1:0]    integ_reg;
    logic [W-1:0]    p_reg;
    logic [2*W-1:0]  m1_reg;
    logic [IB-1:0]   acc_reg;
    logic [W-1:0]    rem_reg;
    logic [NB-1:0]   quo_reg;
    logic [W-1:0]    dmag_reg;
    logic            neg_reg;
    logic [CW-1:0]   cnt_reg;
    logic [NB-1:0]   dacc_reg;
    logic [W-1:0]    drive_reg;

    logic signed [W:0]     mul_a;
    logic signed [W:0]     mul_b;
    logic signed [2*W+1:0] prod;
    logic signed [W:0]     diff;
    logic [W:0]            diff_mag;
    logic [W-1:0]          dt_mag;
    logic [W-1:0]          shifted;
    logic                  ge;
    logic [IB-1:0]         acc_i3;
    logic [W-1:0]          integ_next;
    logic [NB-1:0]         q_fix;

    // Select multiplier operands for the current step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            pidc_pkg::ST_MUL_P:
            begin
                mul_a = {kp[W-1], kp};
                mul_b = {e_reg[W-1], e_reg};
            end
            pidc_pkg::ST_MUL_I1:
            begin
                mul_a = {ki[W-1], ki};
                mul_b = {e_reg[W-1], e_reg};
            end
            pidc_pkg::ST_MUL_I2:
            begin
                mul_a = {m1_reg[2*W-1], m1_reg[2*W-1:W]};
                mul_b = {time_step[W-1], time_step};
            end
            pidc_pkg::ST_MUL_I3:
            begin
                mul_a = {1'b0, m1_reg[W-1:0]};
                mul_b = {time_step[W-1], time_step};
            end
            pidc_pkg::ST_MUL_D1:
            begin
                mul_a = {kd[W-1], kd};
                mul_b = {1'b0, quo_reg[W-1:0]};
            end
            pidc_pkg::ST_MUL_D2:
            begin
                mul_a = {kd[W-1], kd};
                mul_b = {{(W + 1 - F){1'b0}}, quo_reg[NB-1:W]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Divider setup: magnitudes of the error difference and the time step
    assign diff     = {e_reg[W-1], e_reg} - {last_e_reg[W-1], last_e_reg};
    assign diff_mag = diff[W] ? (~diff + 1'b1) : diff;
    assign dt_mag   = time_step[W-1] ? (~time_step + 1'b1) : time_step;

    // One restoring divide step
    assign shifted = {rem_reg[W-2:0], quo_reg[NB-1]};
    assign ge      = (shifted >= dmag_reg);

    // Integral increment closes on the low partial product
    assign acc_i3     = acc_reg + IB'(prod);
    assign integ_next = integ_reg + acc_i3[IB-1:2*F];

    // Floor correction of the truncated quotient
    assign q_fix = neg_reg ? (~quo_reg + NB'(rem_reg == '0)) : quo_reg;

    // Sequencer and state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pidc_pkg::ST_IDLE;
            integ_reg  <= '0;
            last_e_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                pidc_pkg::ST_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        e_reg     <= target - measured;
                        state_reg <= pidc_pkg::ST_MUL_P;
                    end
                end
                pidc_pkg::ST_MUL_P:
                begin
                    p_reg     <= prod[F+W-1:F];
                    quo_reg   <= {diff_mag[W-1:0], {F{1'b0}}};
                    rem_reg   <= '0;
                    dmag_reg  <= dt_mag;
                    neg_reg   <= diff[W] ^ time_step[W-1];
                    cnt_reg   <= CW'(NB - 1);
                    dacc_reg  <= '0;
                    state_reg <= pidc_pkg::ST_MUL_I1;
                end
                pidc_pkg::ST_MUL_I1:
                begin
                    m1_reg    <= prod[2*W-1:0];
                    state_reg <= pidc_pkg::ST_MUL_I2;
                end
                pidc_pkg::ST_MUL_I2:
                begin
                    acc_reg   <= IB'({prod, {W{1'b0}}});
                    state_reg <= pidc_pkg::ST_MUL_I3;
                end
                pidc_pkg::ST_MUL_I3:
                begin
                    integ_reg <= integ_next;
                    // Zero time step: no derivative term
                    if (time_step == '0)
                        state_reg <= pidc_pkg::ST_SUM;
                    else
                        state_reg <= pidc_pkg::ST_DIV;
                end
                pidc_pkg::ST_DIV:
                begin
                    rem_reg <= ge ? (shifted - dmag_reg) : shifted;
                    quo_reg <= {quo_reg[NB-2:0], ge};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= pidc_pkg::ST_FIX;
                end
                pidc_pkg::ST_FIX:
                begin
                    quo_reg   <= q_fix;
                    state_reg <= pidc_pkg::ST_MUL_D1;
                end
                pidc_pkg::ST_MUL_D1:
                begin
                    dacc_reg  <= NB'(prod);
                    state_reg <= pidc_pkg::ST_MUL_D2;
                end
                pidc_pkg::ST_MUL_D2:
                begin
                    dacc_reg  <= dacc_reg + NB'({prod, {W{1'b0}}});
                    state_reg <= pidc_pkg::ST_SUM;
                end
                pidc_pkg::ST_SUM:
                begin
                    drive_reg  <= p_reg + integ_reg + dacc_reg[NB-1:F];
                    last_e_reg <= e_reg;
                    state_reg  <= pidc_pkg::ST_DONE;
                end
                pidc_pkg::ST_DONE:
                begin
                    if (ctrl.take)
                        state_reg <= pidc_pkg::ST_IDLE;
                end
                default:
                begin
                    state_reg <= pidc_pkg::ST_IDLE;
                end
            endcase
        end
    end

    assign stat.idle = (state_reg == pidc_pkg::ST_IDLE);
    assign stat.done = (state_reg == pidc_pkg::ST_DONE);
    assign drive     = drive_reg;

endmodule

`default_nettype wire

/* rtl/pidc_merge.sv */
`default_nettype none

module pidc_merge #(
    parameter int VALUE_WIDTH = pidc_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire pidc_pkg::lane_stat_t   lane_stat  [pidc_pkg::AXIS_COUNT],
    input  wire logic [VALUE_WIDTH-1:0] lane_drive [pidc_pkg::AXIS_COUNT],
    output logic                        take,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [VALUE_WIDTH-1:0]      drive      [pidc_pkg::AXIS_COUNT]
);

    logic                   all_done;
    logic                   out_valid_reg;
    logic [VALUE_WIDTH-1:0] drive_reg [pidc_pkg::AXIS_COUNT];

    // Wait until every lane holds its result
    always_comb
    begin
        all_done = 1'b1;
        for (int a = 0; a < pidc_pkg::AXIS_COUNT; a++)
            all_done = all_done & lane_stat[a].done;
    end

    // Load the output register when it is empty or being drained
    assign take = all_done && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Hold the result item while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int a = 0; a < pidc_pkg::AXIS_COUNT; a++)
                drive_reg[a] <= lane_drive[a];
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

endmodule

`default_nettype wire

/* rtl/pidc_checker.sv */
`default_nettype none

module pidc_checker #(
    parameter int VALUE_WIDTH = pidc_pkg::VALUE_WIDTH_DEF
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_ready,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic [VALUE_WIDTH-1:0] roll_drive,
    input wire logic [VALUE_WIDTH-1:0] pitch_drive,
    input wire logic [VALUE_WIDTH-1:0] yaw_drive
);

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(roll_drive) && $stable(pitch_drive) && $stable(yaw_drive))
        else $error("result item changed while stalled");

    // One item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while lanes busy");

    // A fresh item cannot produce a result in the next cycle
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result item appeared without lane work");

endmodule

bind three_axis_pid_controller pidc_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_pidc_checker (.*);

`default_nettype wire

/* tb/sv/three_axis_pid_controller_tb.sv */
`timescale 1ns / 100ps

module three_axis_pid_controller_tb;

    localparam int VW         = pidc_pkg::VALUE_WIDTH_DEF;
    localparam int DATA_W     = 64;
    localparam int ADDR_W     = $clog2(8 * pidc_pkg::REG_COUNT);
    localparam int IDLE_PCT   = 8;
    localparam int HOLD_LEN   = 400;
    localparam int DOG_LIMIT  = 3000;
    localparam int PHASE_LEN  = 50;
    localparam int PHASES     = 8;

    typedef logic signed [VW-1:0] q97_t;

    typedef struct packed {
        q97_t roll_t;
        q97_t roll_m;
        q97_t pitch_t;
        q97_t pitch_m;
        q97_t yaw_t;
        q97_t yaw_m;
    } angles_t;

    typedef struct packed {
        q97_t roll;
        q97_t pitch;
        q97_t yaw;
    } drives_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid;
    logic              in_ready;
    logic              out_valid;
    logic              out_ready;
    logic [VW-1:0]     roll_drive;
    logic [VW-1:0]     pitch_drive;
    logic [VW-1:0]     yaw_drive;
    angles_t           cur_angles;

    // Controller copy: gains, time step, integrals and previous errors
    logic [3*VW-1:0]   gain_q [pidc_pkg::AXIS_COUNT];
    q97_t              time_step_q;
    q97_t              integ_q [pidc_pkg::AXIS_COUNT];
    q97_t              prev_err_q [pidc_pkg::AXIS_COUNT];

    angles_t           angle_q [$];
    drives_t           drive_q [$];
    logic              in_fire;
    logic              hold_req;
    logic              quiet;
    int                hold_cnt;
    int                dog_cnt;
    int                errors;

    three_axis_pid_controller dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .roll_target    (cur_angles.roll_t),
        .roll_measured  (cur_angles.roll_m),
        .pitch_target   (cur_angles.pitch_t),
        .pitch_measured (cur_angles.pitch_m),
        .yaw_target     (cur_angles.yaw_t),
        .yaw_measured   (cur_angles.yaw_m),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .roll_drive     (roll_drive),
        .pitch_drive    (pitch_drive),
        .yaw_drive      (yaw_drive)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic q97_t wrap16(longint v);
        return v[VW-1:0];
    endfunction

    function automatic longint floor_quot(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && ((num < 0) != (den < 0)))
            q = q - 1;
        return q;
    endfunction

    // Advance the controller copy by one tick and return the three drives
    function automatic drives_t pid_update(angles_t a);
        q97_t    tgt [pidc_pkg::AXIS_COUNT];
        q97_t    meas [pidc_pkg::AXIS_COUNT];
        q97_t    outv [pidc_pkg::AXIS_COUNT];
        longint  kp, ki, kd, e, p, d, dtv;
        drives_t r;
        int      ax;
        tgt[pidc_pkg::AXIS_ROLL]   = a.roll_t;
        meas[pidc_pkg::AXIS_ROLL]  = a.roll_m;
        tgt[pidc_pkg::AXIS_PITCH]  = a.pitch_t;
        meas[pidc_pkg::AXIS_PITCH] = a.pitch_m;
        tgt[pidc_pkg::AXIS_YAW]    = a.yaw_t;
        meas[pidc_pkg::AXIS_YAW]   = a.yaw_m;
        dtv = time_step_q;
        for (ax = 0; ax < pidc_pkg::AXIS_COUNT; ax++)
        begin
            kp = $signed(gain_q[ax][VW-1:0]);
            ki = $signed(gain_q[ax][2*VW-1:VW]);
            kd = $signed(gain_q[ax][3*VW-1:2*VW]);
            e  = wrap16(longint'(tgt[ax]) - longint'(meas[ax]));
            p  = wrap16((kp * e) >>> pidc_pkg::FRAC_BITS);
            integ_q[ax] = wrap16(integ_q[ax]
                                 + ((ki * e * dtv) >>> (2 * pidc_pkg::FRAC_BITS)));
            // No derivative and no divide when the time step is zero
            d = 0;
            if (dtv != 0)
                d = wrap16((kd * floor_quot((e - prev_err_q[ax]) <<< pidc_pkg::FRAC_BITS,
                                            dtv))
                           >>> pidc_pkg::FRAC_BITS);
            prev_err_q[ax] = e;
            outv[ax] = wrap16(p + integ_q[ax] + d);
        end
        r.roll  = outv[pidc_pkg::AXIS_ROLL];
        r.pitch = outv[pidc_pkg::AXIS_PITCH];
        r.yaw   = outv[pidc_pkg::AXIS_YAW];
        return r;
    endfunction

    task automatic check_drive(string name, q97_t want, q97_t got);
        if (want !== got)
        begin
            errors++;
            $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Driver: hold the item until taken, then offer the next one or idle
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_fire)
        begin
            if (angle_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
            begin
                cur_angles <= angle_q.pop_front();
                in_valid   <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_req && hold_cnt < HOLD_LEN)
        begin
            hold_cnt  <= hold_cnt + 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= quiet || $urandom_range(99) >= IDLE_PCT;
    end

    // Monitor: predict on input items, compare on output items
    always @(posedge clk)
    begin
        drives_t want;
        in_fire <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                drive_q.push_back(pid_update(cur_angles));
            if (out_valid && out_ready)
            begin
                if (drive_q.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected item: expected none, actual %0d %0d %0d",
                             $time, $signed(roll_drive), $signed(pitch_drive),
                             $signed(yaw_drive));
                end
                else
                begin
                    want = drive_q.pop_front();
                    check_drive("roll_drive", want.roll, roll_drive);
                    check_drive("pitch_drive", want.pitch, pitch_drive);
                    check_drive("yaw_drive", want.yaw, yaw_drive);
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on any port
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            dog_cnt <= 0;
        else
            dog_cnt <= dog_cnt + 1;
        if (dog_cnt >= DOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(int idx, logic [DATA_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 8);
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == pidc_pkg::REG_TIME_STEP)
            time_step_q = val[VW-1:0];
        else
            gain_q[idx] = val[3*VW-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(logic [3*VW-1:0] g_roll, logic [3*VW-1:0] g_pitch,
                              logic [3*VW-1:0] g_yaw, q97_t dt);
        write_reg(pidc_pkg::AXIS_ROLL, DATA_W'(g_roll));
        write_reg(pidc_pkg::AXIS_PITCH, DATA_W'(g_pitch));
        write_reg(pidc_pkg::AXIS_YAW, DATA_W'(g_yaw));
        write_reg(pidc_pkg::REG_TIME_STEP, DATA_W'($unsigned(dt)));
    endtask

    // Hold until every item is sent and every drive has come back
    task automatic wait_idle();
        do @(posedge clk); while (angle_q.size() != 0 || in_valid || drive_q.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic push_angles(int rt, int rm, int pt, int pm, int yt, int ym);
        angles_t a;
        a.roll_t  = q97_t'(rt);
        a.roll_m  = q97_t'(rm);
        a.pitch_t = q97_t'(pt);
        a.pitch_m = q97_t'(pm);
        a.yaw_t   = q97_t'(yt);
        a.yaw_m   = q97_t'(ym);
        angle_q.push_back(a);
    endtask

    // Mostly tracking loops with small errors, sometimes arbitrary angles
    task automatic push_random();
        int t [3];
        int m [3];
        int ax;
        for (ax = 0; ax < 3; ax++)
        begin
            if ($urandom_range(9) < 6)
            begin
                t[ax] = int'($urandom_range(4000)) - 2000;
                m[ax] = t[ax] + int'($urandom_range(400)) - 200;
            end
            else
            begin
                t[ax] = $urandom;
                m[ax] = $urandom;
            end
        end
        push_angles(t[0], m[0], t[1], m[1], t[2], m[2]);
    endtask

    function automatic logic [3*VW-1:0] pick_gains();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(5))
            0: return {3{16'h7FFF}};
            1: return {3{16'h8000}};
            2: return raw[3*VW-1:0];
            default:
                return {q97_t'(int'($urandom_range(1024)) - 512),
                        q97_t'(int'($urandom_range(1024)) - 512),
                        q97_t'(int'($urandom_range(1024)) - 512)};
        endcase
    endfunction

    function automatic q97_t pick_step();
        case ($urandom_range(7))
            0: return 16'sd0;
            1:
            begin
                case ($urandom_range(3))
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return 16'sd1;
                    default: return -16'sd1;
                endcase
            end
            2: return q97_t'(-int'($urandom_range(512, 1)));
            3: return q97_t'($urandom);
            default: return q97_t'($urandom_range(512, 16));
        endcase
    endfunction

    // Stimulus and phase control
    initial
    begin
        int ph;
        clk        = 1'b0;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        out_ready  = 1'b0;
        cur_angles = '0;
        in_fire    = 1'b0;
        hold_req   = 1'b0;
        quiet      = 1'b0;
        hold_cnt   = 0;
        dog_cnt    = 0;
        errors     = 0;
        for (int ax = 0; ax < pidc_pkg::AXIS_COUNT; ax++)
        begin
            gain_q[ax]     = '0;
            integ_q[ax]    = '0;
            prev_err_q[ax] = '0;
        end
        time_step_q = q97_t'(pidc_pkg::DT_ONE);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: first tick from zero integral, extremes, error wrap
        set_config({16'd32, 16'd64, 16'd128}, {16'hFFC0, 16'd200, 16'h0100},
                   {16'd7, 16'hFF00, 16'hFF80}, q97_t'(pidc_pkg::DT_ONE));
        push_angles(100, 0, -50, 20, 300, 299);
        push_angles(0, 0, 0, 0, 0, 0);
        push_angles(32767, -32768, -32768, 32767, 32767, 32767);
        push_angles(-32768, -32768, 32767, -32768, -32768, 32767);
        push_angles(-1, 0, 1, -1, 128, -128);
        push_angles(-1, -1, -1, -1, -1, -1);
        wait_idle();

        // Zero time step: no derivative, integral holds
        write_reg(pidc_pkg::REG_TIME_STEP, '0);
        push_angles(500, -500, 1000, 0, -200, 200);
        push_angles(-300, 300, 0, 1000, 200, -200);
        wait_idle();

        // Negative time steps, down to the most negative
        write_reg(pidc_pkg::REG_TIME_STEP, DATA_W'(16'hFF80));
        push_angles(400, 0, -400, 0, 10, -10);
        push_angles(-400, 0, 400, 0, -10, 10);
        wait_idle();
        write_reg(pidc_pkg::REG_TIME_STEP, DATA_W'(16'h8000));
        push_angles(32767, 0, -32768, 0, 1, 0);
        wait_idle();

        // Extreme gains with the largest and the smallest time step
        set_config({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, 16'sh7FFF);
        push_angles(32767, -32768, -32768, 32767, 12345, -12345);
        push_angles(-32768, 32767, 32767, -32768, -1, 1);
        wait_idle();
        set_config({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 16'sd1);
        push_angles(32767, -32768, -32768, 32767, 0, 1);
        push_angles(-32768, 32767, 32767, -32768, 1, 0);
        push_angles(16384, -16384, -21000, 21000, 255, -255);
        wait_idle();

        // Random phases; one with a long receiver hold, one with no idling
        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            set_config(pick_gains(), pick_gains(), pick_gains(), pick_step());
            quiet = (ph == 5);
            if (ph == 2)
                hold_req = 1'b1;
            repeat (PHASE_LEN) push_random();
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (drive_q.size() != 0)
        begin
            errors++;
            $display("%0t missing items: expected %0d, actual 0", $time, drive_q.size());
        end
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
